### src/spq_pkg.sv
`default_nettype none

package spq_pkg;

   // Default number of entries held by the queue.
   localparam int SPQ_DEPTH = 16;

   typedef enum logic [1:0] {
      ACT_ENQUEUE = 2'd0,
      ACT_DEQUEUE = 2'd1,
      ACT_CLEAR   = 2'd2,
      ACT_SPARE   = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_ENQUEUED = 3'd0,
      ST_DEQUEUED = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_FULL     = 3'd3,
      ST_CLEARED  = 3'd4
   } status_type;

   // Command broadcast to every cell of the chain in the same cycle.
   typedef struct packed {
      logic               enq;
      logic               deq;
      logic               clr;
      logic signed [31:0] data;
      logic signed [31:0] prio;
   } cmd_type;

   // What a cell shows its neighbors.
   typedef struct packed {
      logic               valid;
      logic               keep;
      logic signed [31:0] data;
      logic signed [31:0] prio;
   } link_type;

endpackage

`default_nettype wire

### src/spq_cell.sv
`default_nettype none

module spq_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire spq_pkg::cmd_type  cmd,
   input  wire spq_pkg::link_type left_link,
   input  wire spq_pkg::link_type right_link,
   output spq_pkg::link_type      link
);
   import spq_pkg::*;

   logic               valid_ff, valid_in;
   logic signed [31:0] data_ff, data_in;
   logic signed [31:0] prio_ff, prio_in;
   logic               keep;

   // An occupied cell with priority greater than or equal to the new word stays put.
   assign keep = valid_ff & (prio_ff >= cmd.prio);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      prio_in  = prio_ff;
      if (cmd.clr) begin
         valid_in = 1'b0;
      end else if (cmd.deq) begin
         valid_in = right_link.valid;
         data_in  = right_link.data;
         prio_in  = right_link.prio;
      end else if (cmd.enq && !keep) begin
         if (left_link.keep) begin
            valid_in = 1'b1;
            data_in  = cmd.data;
            prio_in  = cmd.prio;
         end else begin
            valid_in = left_link.valid;
            data_in  = left_link.data;
            prio_in  = left_link.prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      prio_ff <= prio_in;
   end

   assign link.valid = valid_ff;
   assign link.keep  = keep;
   assign link.data  = data_ff;
   assign link.prio  = prio_ff;

endmodule

`default_nettype wire

### src/stable_priority_queue_top.sv
`default_nettype none

// Bounded priority queue, highest priority first, first-in first-out among
// equal priorities. Each transaction on the req_ channel is an enqueue, a
// dequeue or a clear, and each produces exactly one transaction on the rsp_
// channel carrying a status, the removed data word for a successful dequeue
// (zero otherwise) and a flag telling whether the queue is empty afterwards.
// The store is a row of DEPTH identical cells, slot 0 being the head; every
// cell compares its own priority with the incoming one and, in the same
// cycle, either holds, takes the new word or takes its neighbor's entry.
// One transaction is accepted per cycle whenever the result register is
// empty or being drained; the result is registered and appears in the cycle
// after acceptance. An enqueue into a full queue is rejected with the full
// status and leaves the contents untouched.
module stable_priority_queue_top #(
   parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_action,
   input  wire logic signed [31:0] req_data_in,
   input  wire logic signed [31:0] req_priority_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_status,
   output logic signed [31:0]      rsp_data_out,
   output logic                    rsp_queue_empty
);
   import spq_pkg::*;

   link_type             links [DEPTH];
   logic [DEPTH-1:0]     occupied;
   cmd_type              cmd;
   logic                 accept;
   logic                 full;
   action_type           action;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           status_ff, status_in;
   logic signed [31:0]   data_out_ff, data_out_in;
   logic                 empty_ff, empty_in;

   // The result register frees up as soon as the downstream side takes it.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign action    = action_type'(req_action);
   assign full      = occupied[DEPTH-1];

   // Only commands that really change the store reach the cells.
   always_comb begin
      cmd.enq  = accept && (action == ACT_ENQUEUE) && !full;
      cmd.deq  = accept && (action == ACT_DEQUEUE) && occupied[0];
      cmd.clr  = accept && (action != ACT_ENQUEUE) && (action != ACT_DEQUEUE);
      cmd.data = req_data_in;
      cmd.prio = req_priority_in;
   end

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         link_type left_link;
         link_type right_link;
         if (i == 0) begin : g_head
            // The head sees a virtual neighbor that always holds its place.
            assign left_link = '{valid: 1'b0, keep: 1'b1, data: '0, prio: '0};
         end else begin : g_body
            assign left_link = links[i-1];
         end
         if (i == DEPTH - 1) begin : g_tail
            assign right_link = '{valid: 1'b0, keep: 1'b0, data: '0, prio: '0};
         end else begin : g_inner
            assign right_link = links[i+1];
         end
         spq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .left_link  (left_link),
            .right_link (right_link),
            .link       (links[i])
         );
         assign occupied[i] = links[i].valid;
      end
   endgenerate

   // Result of the accepted transaction, computed from the store before it moves.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      data_out_in  = data_out_ff;
      empty_in     = empty_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         data_out_in  = '0;
         unique case (action)
            ACT_ENQUEUE: begin
               status_in = full ? ST_FULL : ST_ENQUEUED;
               empty_in  = 1'b0;
            end
            ACT_DEQUEUE: begin
               if (occupied[0]) begin
                  status_in   = ST_DEQUEUED;
                  data_out_in = links[0].data;
                  empty_in    = !occupied[1];
               end else begin
                  status_in = ST_EMPTY;
                  empty_in  = 1'b1;
               end
            end
            default: begin
               status_in = ST_CLEARED;
               empty_in  = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff   <= status_in;
      data_out_ff <= data_out_in;
      empty_ff    <= empty_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_data_out    = data_out_ff;
   assign rsp_queue_empty = empty_ff;

   // Occupied cells always form an unbroken run starting at the head.
   assert property (@(posedge clock) disable iff (reset)
      ((occupied + DEPTH'(1)) & occupied) == '0)
      else $error("occupied cells are not contiguous from the head");

   // A successful enqueue leaves the head occupied.
   assert property (@(posedge clock) disable iff (reset)
      cmd.enq |=> occupied[0])
      else $error("head empty after enqueue");

   // The empty flag of a result agrees with the store once it has settled.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (empty_ff == !occupied[0]))
      else $error("queue_empty disagrees with the store");

   // Data is only reported for a successful dequeue.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff != ST_DEQUEUED)) |-> (data_out_ff == '0))
      else $error("nonzero data on a result that is not a dequeue");

endmodule

`default_nettype wire

### sim/stable_priority_queue_top_tb.sv
`default_nettype none

module stable_priority_queue_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import spq_pkg::*;

   localparam int DEPTH = SPQ_DEPTH;

   // One result transaction as the queue should report it.
   typedef struct packed {
      status_type         status;
      logic signed [31:0] data;
      logic               empty;
   } queue_result_type;

   // One row of the directed stimulus. A row may be repeated, with the data
   // word stepping by one on each repetition. Rows whose result is obvious
   // carry it typed in; the others are checked against the predictor.
   typedef struct packed {
      action_type         act;
      logic signed [31:0] data;
      logic signed [31:0] prio;
      int unsigned        reps;
      logic               typed;
      queue_result_type   res;
   } directed_row_type;

   localparam logic signed [31:0] PRIO_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] PRIO_MIN = 32'sh8000_0000;
   localparam int NUM_ROWS = 16;

   localparam directed_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      // Dequeue and clear on the empty queue straight out of reset, and the
      // unused action code, which behaves as a clear.
      '{ACT_DEQUEUE, 32'sh0,        32'sh0,   1, 1'b1, '{ST_EMPTY,    32'sh0, 1'b1}},
      '{ACT_CLEAR,   32'sh0,        32'sh0,   1, 1'b1, '{ST_CLEARED,  32'sh0, 1'b1}},
      '{ACT_SPARE,   32'sh1234,     32'sh55,  1, 1'b1, '{ST_CLEARED,  32'sh0, 1'b1}},
      // Extreme data words and priorities.
      '{ACT_ENQUEUE, PRIO_MAX,      PRIO_MAX, 1, 1'b1, '{ST_ENQUEUED, 32'sh0, 1'b0}},
      '{ACT_ENQUEUE, PRIO_MIN,      PRIO_MIN, 1, 1'b1, '{ST_ENQUEUED, 32'sh0, 1'b0}},
      // Equal priorities must leave in arrival order.
      '{ACT_ENQUEUE, 32'sh0,        32'sh0,   1, 1'b0, '0},
      '{ACT_ENQUEUE, 32'sh1,        32'sh0,   1, 1'b0, '0},
      '{ACT_ENQUEUE, -32'sh1,       -32'sh1,  1, 1'b0, '0},
      '{ACT_ENQUEUE, 32'sh100,      PRIO_MAX, 1, 1'b0, '0},
      // Fill up to the last free slot, then try one more.
      '{ACT_ENQUEUE, 32'sh1000,     32'sh5,  10, 1'b0, '0},
      '{ACT_ENQUEUE, 32'sh5a5a_a5a5, PRIO_MAX, 1, 1'b1, '{ST_FULL,    32'sh0, 1'b0}},
      // Payload on a dequeue or a clear is ignored.
      '{ACT_DEQUEUE, 32'shdead_beef, PRIO_MAX, 4, 1'b0, '0},
      '{ACT_CLEAR,   32'shffff_ffff, PRIO_MIN, 1, 1'b1, '{ST_CLEARED, 32'sh0, 1'b1}},
      '{ACT_DEQUEUE, 32'sh0,        32'sh0,   1, 1'b1, '{ST_EMPTY,    32'sh0, 1'b1}},
      // A single entry in and out again empties the queue.
      '{ACT_ENQUEUE, 32'shcafe_f00d, 32'sh0,  1, 1'b0, '0},
      '{ACT_DEQUEUE, 32'sh0,        32'sh0,   1, 1'b0, '0}
   };

   localparam int RANDOM_PER_PHASE = 650;
   localparam int TAIL_CYCLES      = 10;

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_ready;
   logic [1:0]         req_action      = ACT_CLEAR;
   logic signed [31:0] req_data_in     = '0;
   logic signed [31:0] req_priority_in = '0;
   logic               rsp_valid;
   logic               rsp_ready       = 1'b0;
   logic [2:0]         rsp_status;
   logic signed [31:0] rsp_data_out;
   logic               rsp_queue_empty;

   // Percentages of cycles in which the sender holds back and in which the
   // receiver refuses a result. They change between the phases of the run.
   int unsigned send_idle_pct  = 17;
   int unsigned recv_stall_pct = 81;

   // Shadow copy of the sorted store, head in slot 0.
   logic signed [31:0] shadow_data [DEPTH];
   logic signed [31:0] shadow_prio [DEPTH];
   int unsigned        shadow_count = 0;

   // Results still owed by the queue, oldest at the front.
   queue_result_type pending_results [$];

   int unsigned error_count  = 0;
   int unsigned result_index = 0;

   stable_priority_queue_top #(
      .DEPTH(DEPTH)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_data_in     (req_data_in),
      .req_priority_in (req_priority_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_data_out    (rsp_data_out),
      .rsp_queue_empty (rsp_queue_empty)
   );

   always #5 clock = ~clock;

   // Apply one action to the shadow store and return the result it yields.
   // A new word goes behind every entry of greater or equal priority, which
   // is what keeps equal priorities in arrival order.
   function automatic queue_result_type apply_queue_action(input action_type act,
                                                           input logic signed [31:0] data,
                                                           input logic signed [31:0] prio);
      queue_result_type res;
      int unsigned      pos;
      res = '{ST_CLEARED, 32'sh0, 1'b0};
      case (act)
         ACT_ENQUEUE: begin
            if (shadow_count >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               pos = 0;
               while (pos < shadow_count && shadow_prio[pos] >= prio) begin
                  pos++;
               end
               for (int k = int'(shadow_count); k > int'(pos); k--) begin
                  shadow_data[k] = shadow_data[k-1];
                  shadow_prio[k] = shadow_prio[k-1];
               end
               shadow_data[pos] = data;
               shadow_prio[pos] = prio;
               shadow_count++;
               res.status = ST_ENQUEUED;
            end
         end
         ACT_DEQUEUE: begin
            if (shadow_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.data = shadow_data[0];
               for (int k = 1; k < int'(shadow_count); k++) begin
                  shadow_data[k-1] = shadow_data[k];
                  shadow_prio[k-1] = shadow_prio[k];
               end
               shadow_count--;
               res.status = ST_DEQUEUED;
            end
         end
         default: begin
            // Both the clear code and the unused code empty the queue.
            shadow_count = 0;
            res.status   = ST_CLEARED;
         end
      endcase
      res.empty = (shadow_count == 0);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] result %0d: %s is %h, expected %h", $realtime, result_index,
               what, got, want);
      error_count++;
   endtask

   // Present one request transaction and hold it until it is accepted. The
   // expectation is pushed at the accepting edge, so the store of pending
   // results only ever holds work that the queue has actually taken.
   task automatic send_request(input action_type act, input logic signed [31:0] data,
                               input logic signed [31:0] prio, input logic typed,
                               input queue_result_type typed_res);
      queue_result_type predicted;
      predicted = apply_queue_action(act, data, prio);
      // Random gap before the transaction; valid drops only when a gap is
      // actually taken, so back-to-back transactions keep valid high.
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_data_in     <= data;
      req_priority_in <= prio;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      pending_results.push_back(typed ? typed_res : predicted);
   endtask

   // The receiver stalls at random, at a rate set by the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Every accepted result is compared field by field with the oldest
   // expectation. A result that nobody asked for counts as a failure too.
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, status", {29'b0, rsp_status}, 32'h0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               report_mismatch("status", {29'b0, rsp_status}, {29'b0, want.status});
            end
            if (rsp_data_out !== want.data) begin
               report_mismatch("data_out", rsp_data_out, want.data);
            end
            if (rsp_queue_empty !== want.empty) begin
               report_mismatch("queue_empty", {31'b0, rsp_queue_empty}, {31'b0, want.empty});
            end
         end
         result_index++;
      end
   end

   // Main stimulus: reset, the directed table, then three random phases
   // with different idling on each side, and finally a drain of results.
   initial begin
      action_type         act;
      logic signed [31:0] prio;
      int unsigned        pick;
      logic               filling;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int row = 0; row < NUM_ROWS; row++) begin
         for (int rep = 0; rep < DIRECTED_ROWS[row].reps; rep++) begin
            send_request(DIRECTED_ROWS[row].act, DIRECTED_ROWS[row].data + rep,
                         DIRECTED_ROWS[row].prio, DIRECTED_ROWS[row].typed,
                         DIRECTED_ROWS[row].res);
         end
      end

      filling = 1'b1;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 17;
               recv_stall_pct = 81;
            end
            1: begin
               send_idle_pct  = 81;
               recv_stall_pct = 17;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // Alternate between stretches that mostly fill the queue and
            // stretches that mostly drain it, so that both the full and the
            // empty corners are visited often.
            if (n % 40 == 0) begin
               filling = 1'($urandom_range(0, 1));
            end
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
               act = ACT_CLEAR;
            end else if (pick < 3) begin
               act = ACT_SPARE;
            end else if (pick < (filling ? 70 : 35)) begin
               act = ACT_ENQUEUE;
            end else begin
               act = ACT_DEQUEUE;
            end
            // Small priorities collide often and exercise arrival order;
            // extremes check the signed compare at its limits.
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
               prio = $urandom_range(0, 3);
            end else if (pick < 6) begin
               case ($urandom_range(0, 3))
                  0: prio = PRIO_MAX;
                  1: prio = PRIO_MIN;
                  2: prio = -32'sh1;
                  default: prio = 32'sh0;
               endcase
            end else begin
               prio = $urandom;
            end
            send_request(act, $urandom, prio, 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("** stable_priority_queue_top: PASSED **");
      end else begin
         $display("** stable_priority_queue_top: FAILED **");
      end
      $finish;
   end

   // Safety net in case the handshake hangs.
   initial begin
      #5_000_000;
      $display("** stable_priority_queue_top: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
